// ===== rtl/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex integer arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int RES_BITS = 33;

   typedef logic [1:0] op_type;

   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_SUB = 2'd1;
   localparam op_type OP_MUL = 2'd2;
   localparam op_type OP_DIV = 2'd3;

   typedef logic [RES_BITS-1:0] res_type;

   // fields that ride alongside the divider datapath
   typedef struct packed {
      logic    is_div;
      logic    dz;
      logic    sign_r;
      logic    sign_i;
      res_type res_r;
      res_type res_i;
   } cau_side_type;

endpackage
`default_nettype wire

// ===== rtl/cau_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: opcode and two complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if
   import cau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   op_type                          op;
   logic signed [OPERAND_WIDTH-1:0] a_real;
   logic signed [OPERAND_WIDTH-1:0] a_imag;
   logic signed [OPERAND_WIDTH-1:0] b_real;
   logic signed [OPERAND_WIDTH-1:0] b_imag;

   modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, op, a_real, a_imag, b_real, b_imag, output ready);
endinterface
`default_nettype wire

// ===== rtl/cau_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex result and zero divisor flag.
// ----------------------------------------------------------------------------
interface cau_rsp_if
   import cau_pkg::*;
;
   logic    valid;
   logic    ready;
   res_type res_real;
   res_type res_imag;
   logic    div_zero;

   modport source (output valid, res_real, res_imag, div_zero, input ready);
   modport sink   (input valid, res_real, res_imag, div_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/cau_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_stage
// One registered restoring divide step for the real and imaginary quotients.
// ----------------------------------------------------------------------------
module cau_div_stage
   import cau_pkg::*;
#(
   parameter int DW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] den_i,
   input  wire logic [DW-1:0] rem_r_i,
   input  wire logic [DW-1:0] pq_r_i,
   input  wire logic [DW-1:0] rem_i_i,
   input  wire logic [DW-1:0] pq_i_i,
   input  wire cau_side_type  side_i,
   output logic               out_valid,
   output logic [DW-1:0]      den_o,
   output logic [DW-1:0]      rem_r_o,
   output logic [DW-1:0]      pq_r_o,
   output logic [DW-1:0]      rem_i_o,
   output logic [DW-1:0]      pq_i_o,
   output cau_side_type       side_o
);

   function automatic logic [2*DW-1:0] div_step(
      input logic [DW-1:0] rem,
      input logic [DW-1:0] pq,
      input logic [DW-1:0] den
   );
      logic [DW:0]   t;
      logic [DW:0]   d;
      logic [DW-1:0] rn;
      logic          qb;
      t  = {rem, pq[DW-1]};
      d  = t - {1'b0, den};
      qb = !d[DW];
      rn = qb ? d[DW-1:0] : t[DW-1:0];
      return {rn, pq[DW-2:0], qb};
   endfunction

   logic              valid_ff;
   logic [DW-1:0]     den_ff, rem_r_ff, pq_r_ff, rem_i_ff, pq_i_ff;
   cau_side_type      side_ff;
   logic [2*DW-1:0]   step_r_in, step_i_in;

   assign step_r_in = div_step(rem_r_i, pq_r_i, den_i);
   assign step_i_in = div_step(rem_i_i, pq_i_i, den_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         den_ff   <= den_i;
         rem_r_ff <= step_r_in[2*DW-1:DW];
         pq_r_ff  <= step_r_in[DW-1:0];
         rem_i_ff <= step_i_in[2*DW-1:DW];
         pq_i_ff  <= step_i_in[DW-1:0];
         side_ff  <= side_i;
      end
   end

   assign out_valid = valid_ff;
   assign den_o     = den_ff;
   assign rem_r_o   = rem_r_ff;
   assign pq_r_o    = pq_r_ff;
   assign rem_i_o   = rem_i_ff;
   assign pq_i_o    = pq_i_ff;
   assign side_o    = side_ff;

endmodule
`default_nettype wire

// ===== rtl/complex_arith_unit.sv =====
`default_nettype none
// Throughput: one item per cycle; each stage holds its item on a stall.
// The divider resolves one quotient bit per stage, 2*OPERAND_WIDTH stages.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and truncating divide.
// ----------------------------------------------------------------------------
module complex_arith_unit
   import cau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   cau_req_if.sink  req_if,
   cau_rsp_if.source rsp_if
);

   localparam int W  = OPERAND_WIDTH;
   localparam int DW = 2 * W;
   localparam int SW = (DW + 1 > RES_BITS) ? DW + 1 : RES_BITS;
   localparam int NS = DW + 4;
   localparam int SF = NS - 1;

   logic [NS-1:0] v;
   logic [NS-1:0] en;

   assign en[SF] = !v[SF] || rsp_if.ready;
   for (genvar k = 0; k < SF; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
   end

   assign req_if.ready = en[0];

   // stage A: capture operands
   logic                a_v_ff;
   op_type              a_op_ff;
   logic signed [W-1:0] ar_ff, ai_ff, br_ff, bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en[0]) begin
         a_v_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_op_ff <= req_if.op;
         ar_ff   <= req_if.a_real;
         ai_ff   <= req_if.a_imag;
         br_ff   <= req_if.b_real;
         bi_ff   <= req_if.b_imag;
      end
   end

   assign v[0] = a_v_ff;

   // stage B: products and sums
   logic                 b_v_ff;
   op_type               b_op_ff;
   logic signed [DW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff, p_cc_ff;
   logic signed [W:0]    s_r_ff, s_i_ff;
   logic signed [W:0]    s_r_in, s_i_in;

   always_comb begin
      s_r_in = {ar_ff[W-1], ar_ff} + {br_ff[W-1], br_ff};
      s_i_in = {ai_ff[W-1], ai_ff} + {bi_ff[W-1], bi_ff};
      if (a_op_ff == OP_SUB) begin
         s_r_in = {ar_ff[W-1], ar_ff} - {br_ff[W-1], br_ff};
         s_i_in = {ai_ff[W-1], ai_ff} - {bi_ff[W-1], bi_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en[1]) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_op_ff <= a_op_ff;
         p_rr_ff <= ar_ff * br_ff;
         p_ii_ff <= ai_ff * bi_ff;
         p_ir_ff <= ai_ff * br_ff;
         p_ri_ff <= ar_ff * bi_ff;
         p_bb_ff <= br_ff * br_ff;
         p_cc_ff <= bi_ff * bi_ff;
         s_r_ff  <= s_r_in;
         s_i_ff  <= s_i_in;
      end
   end

   assign v[1] = b_v_ff;

   // stage C: combine products, split divide operands into sign and magnitude
   logic                 c_v_ff;
   cau_side_type         c_side_ff, c_side_in;
   logic [DW-1:0]        c_den_ff, c_mr_ff, c_mi_ff;
   logic [DW-1:0]        c_den_in, c_mr_in, c_mi_in;
   logic signed [DW:0]   m_r, m_i, n_r, n_i;
   logic [DW:0]          abs_r, abs_i;
   logic signed [SW-1:0] x_r, x_i;

   always_comb begin
      m_r      = {p_rr_ff[DW-1], p_rr_ff} - {p_ii_ff[DW-1], p_ii_ff};
      m_i      = {p_ir_ff[DW-1], p_ir_ff} + {p_ri_ff[DW-1], p_ri_ff};
      n_r      = {p_rr_ff[DW-1], p_rr_ff} + {p_ii_ff[DW-1], p_ii_ff};
      n_i      = {p_ir_ff[DW-1], p_ir_ff} - {p_ri_ff[DW-1], p_ri_ff};
      abs_r    = n_r[DW] ? (DW+1)'(-n_r) : n_r;
      abs_i    = n_i[DW] ? (DW+1)'(-n_i) : n_i;
      c_den_in = $unsigned(p_bb_ff) + $unsigned(p_cc_ff);
      c_mr_in  = abs_r[DW-1:0];
      c_mi_in  = abs_i[DW-1:0];
      x_r      = SW'(s_r_ff);
      x_i      = SW'(s_i_ff);
      if (b_op_ff == OP_MUL) begin
         x_r = SW'(m_r);
         x_i = SW'(m_i);
      end
      c_side_in.is_div = (b_op_ff == OP_DIV);
      c_side_in.dz     = (b_op_ff == OP_DIV) && (c_den_in == '0);
      c_side_in.sign_r = n_r[DW];
      c_side_in.sign_i = n_i[DW];
      c_side_in.res_r  = x_r[RES_BITS-1:0];
      c_side_in.res_i  = x_i[RES_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en[2]) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c_side_ff <= c_side_in;
         c_den_ff  <= c_den_in;
         c_mr_ff   <= c_mr_in;
         c_mi_ff   <= c_mi_in;
      end
   end

   assign v[2] = c_v_ff;

   // divider stages
   logic [DW-1:0] d_den   [0:DW];
   logic [DW-1:0] d_rem_r [0:DW];
   logic [DW-1:0] d_pq_r  [0:DW];
   logic [DW-1:0] d_rem_i [0:DW];
   logic [DW-1:0] d_pq_i  [0:DW];
   cau_side_type  d_side  [0:DW];
   logic [DW:0]   d_v;

   assign d_v[0]     = c_v_ff;
   assign d_den[0]   = c_den_ff;
   assign d_rem_r[0] = '0;
   assign d_pq_r[0]  = c_mr_ff;
   assign d_rem_i[0] = '0;
   assign d_pq_i[0]  = c_mi_ff;
   assign d_side[0]  = c_side_ff;

   for (genvar j = 0; j < DW; j++) begin : g_div
      cau_div_stage #(.DW(DW)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .load      (en[3+j]),
         .in_valid  (d_v[j]),
         .den_i     (d_den[j]),
         .rem_r_i   (d_rem_r[j]),
         .pq_r_i    (d_pq_r[j]),
         .rem_i_i   (d_rem_i[j]),
         .pq_i_i    (d_pq_i[j]),
         .side_i    (d_side[j]),
         .out_valid (d_v[j+1]),
         .den_o     (d_den[j+1]),
         .rem_r_o   (d_rem_r[j+1]),
         .pq_r_o    (d_pq_r[j+1]),
         .rem_i_o   (d_rem_i[j+1]),
         .pq_i_o    (d_pq_i[j+1]),
         .side_o    (d_side[j+1])
      );
      assign v[3+j] = d_v[j+1];
   end

   // final stage: apply quotient signs, select result
   logic                 f_v_ff;
   res_type              f_r_ff, f_i_ff, f_r_in, f_i_in;
   logic                 f_dz_ff;
   cau_side_type         q_side;
   logic signed [SW-1:0] q_r, q_i;

   always_comb begin
      q_side = d_side[DW];
      q_r    = $signed(SW'(d_pq_r[DW]));
      q_i    = $signed(SW'(d_pq_i[DW]));
      if (q_side.sign_r) begin
         q_r = -q_r;
      end
      if (q_side.sign_i) begin
         q_i = -q_i;
      end
      f_r_in = q_side.res_r;
      f_i_in = q_side.res_i;
      if (q_side.is_div) begin
         f_r_in = q_side.dz ? '0 : q_r[RES_BITS-1:0];
         f_i_in = q_side.dz ? '0 : q_i[RES_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en[SF]) begin
         f_v_ff <= d_v[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[SF]) begin
         f_r_ff  <= f_r_in;
         f_i_ff  <= f_i_in;
         f_dz_ff <= q_side.dz;
      end
   end

   assign v[SF] = f_v_ff;

   assign rsp_if.valid    = f_v_ff;
   assign rsp_if.res_real = f_r_ff;
   assign rsp_if.res_imag = f_i_ff;
   assign rsp_if.div_zero = f_dz_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> a_v_ff)
      else $error("accepted item did not enter the first stage");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.div_zero) |-> (rsp_if.res_real == '0 && rsp_if.res_imag == '0))
      else $error("zero divisor result is not zero");

   a_dz_div_only: assert property (@(posedge clock) disable iff (reset)
      (c_v_ff && !c_side_ff.is_div) |-> !c_side_ff.dz)
      else $error("zero divisor flag on a non-divide item");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid after reset");

endmodule
`default_nettype wire
